// File: design/tslne_pkg.sv
// tslne_pkg: shared types, register indexes and character codes for the
// text stream line number / escape unit. No dependencies.
`default_nettype none

package tslne_pkg;

   // Default sizes handed to the top-level parameters
   localparam int COUNT_DIGITS_DEF = 10;
   localparam int PAD_WIDTH_DEF    = 6;

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_NUMBER_MODE   = 3'd0;
   localparam logic [2:0] REG_SQUEEZE_BLANK = 3'd1;
   localparam logic [2:0] REG_SHOW_ENDS     = 3'd2;
   localparam logic [2:0] REG_SHOW_TABS     = 3'd3;
   localparam logic [2:0] REG_SHOW_CTRL     = 3'd4;

   // Numbering modes (any other code means no numbering)
   localparam logic [1:0] NUM_ALL       = 2'd1;
   localparam logic [1:0] NUM_TEXT_ONLY = 2'd2;

   // Character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_UPPERI = 8'h49;
   localparam logic [7:0] CH_UPPERM = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_HIGH   = 8'h80;
   localparam logic [7:0] CH_META   = 8'hA0;
   localparam logic [7:0] CH_MAX    = 8'hFF;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       show_ends;
      logic       show_tabs;
      logic       show_ctrl;
   } cfg_type;

   // Rendered character: up to four bytes, entry 0 goes out first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } rend_type;

endpackage

`default_nettype wire

// File: design/tslne_csr.sv
// tslne_csr: APB-style register file for the mode controls.
// Depends on tslne_pkg.
`default_nettype none

module tslne_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tslne_pkg::CSR_AW-1:0] paddr,
   input  logic [tslne_pkg::CSR_DW-1:0] pwdata,
   output logic [tslne_pkg::CSR_DW-1:0] prdata,
   output logic                         pready,
   output tslne_pkg::cfg_type           cfg
);
   import tslne_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_AW-1:2];
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_NUMBER_MODE:   cfg_in.number_mode   = pwdata[1:0];
            REG_SQUEEZE_BLANK: cfg_in.squeeze_blank = pwdata[0];
            REG_SHOW_ENDS:     cfg_in.show_ends     = pwdata[0];
            REG_SHOW_TABS:     cfg_in.show_tabs     = pwdata[0];
            REG_SHOW_CTRL:     cfg_in.show_ctrl     = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_NUMBER_MODE:   prdata[1:0] = cfg_ff.number_mode;
         REG_SQUEEZE_BLANK: prdata[0]   = cfg_ff.squeeze_blank;
         REG_SHOW_ENDS:     prdata[0]   = cfg_ff.show_ends;
         REG_SHOW_TABS:     prdata[0]   = cfg_ff.show_tabs;
         REG_SHOW_CTRL:     prdata[0]   = cfg_ff.show_ctrl;
         default:           prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tslne_core.sv
// tslne_core: input word register, line state, BCD line counter and
// character rendering. Depends on tslne_pkg.
`default_nettype none

module tslne_core #(
   parameter int COUNT_DIGITS = tslne_pkg::COUNT_DIGITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tslne_pkg::cfg_type                 cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [7:0]                         in_byte,
   input  logic                               in_file_start,
   output logic                               item_valid,
   input  logic                               item_ready,
   output logic                               item_num_en,
   output logic [COUNT_DIGITS*4-1:0]          item_digits,
   output logic [$clog2(COUNT_DIGITS+1)-1:0]  item_sig,
   output tslne_pkg::rend_type                item_rend
);
   import tslne_pkg::*;

   localparam int CW    = COUNT_DIGITS * 4;
   localparam int SIG_W = $clog2(COUNT_DIGITS + 1);

   logic          a_valid_ff, a_valid_in;
   logic [7:0]    a_byte_ff, a_byte_in;
   logic          a_fs_ff, a_fs_in;
   logic          prev_nl_ff, prev_nl_in;
   logic          blank_ff, blank_in;
   logic [CW-1:0] count_ff, count_in, count_inc;

   logic          is_nl, prev_eff, blank_eff, first, drop, a_move, num_en, full, lower_nine;
   logic [SIG_W-1:0] sig;
   rend_type      rend;
   logic [7:0]    ch;

   assign ch        = a_byte_ff;
   assign is_nl     = (ch == CH_NL);
   // A file start clears the line state before the word is looked at
   assign prev_eff  = a_fs_ff ? 1'b0 : prev_nl_ff;
   assign blank_eff = a_fs_ff ? 1'b0 : blank_ff;
   assign first     = (count_ff == CW'(1));
   assign drop      = cfg.squeeze_blank && blank_eff && is_nl;

   always_comb begin
      num_en = 1'b0;
      if (cfg.number_mode == NUM_ALL) begin
         num_en = prev_eff || first;
      end else if (cfg.number_mode == NUM_TEXT_ONLY) begin
         num_en = !is_nl && (prev_eff || first);
      end
   end

   // Most significant nonzero digit, at least one digit
   always_comb begin
      sig = SIG_W'(1);
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (count_ff[4*i +: 4] != 4'd0) sig = SIG_W'(i + 1);
      end
   end

   // Saturating BCD increment
   always_comb begin
      full = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (count_ff[4*i +: 4] != 4'd9) full = 1'b0;
      end
      count_inc = count_ff;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         lower_nine = 1'b1;
         for (int j = 0; j < COUNT_DIGITS; j++) begin
            if (j < i && count_ff[4*j +: 4] != 4'd9) lower_nine = 1'b0;
         end
         if (!full && lower_nine) begin
            count_inc[4*i +: 4] = (count_ff[4*i +: 4] == 4'd9) ? 4'd0
                                  : count_ff[4*i +: 4] + 4'd1;
         end
      end
   end

   always_comb begin
      rend.bytes    = '0;
      rend.bytes[0] = ch;
      rend.count    = 3'd1;
      priority if (cfg.show_ends && is_nl) begin
         rend.bytes[0] = CH_DOLLAR;
         rend.bytes[1] = CH_NL;
         rend.count    = 3'd2;
      end else if (cfg.show_tabs && ch == CH_TAB) begin
         rend.bytes[0] = CH_CARET;
         rend.bytes[1] = CH_UPPERI;
         rend.count    = 3'd2;
      end else if (cfg.show_ctrl && ch < CH_SPACE && !is_nl && ch != CH_TAB) begin
         rend.bytes[0] = CH_CARET;
         rend.bytes[1] = ch | 8'h40;
         rend.count    = 3'd2;
      end else if (cfg.show_ctrl && ch == CH_DEL) begin
         rend.bytes[0] = CH_CARET;
         rend.bytes[1] = CH_QMARK;
         rend.count    = 3'd2;
      end else if (cfg.show_ctrl && ch == CH_MAX) begin
         rend.bytes[0] = CH_UPPERM;
         rend.bytes[1] = CH_DASH;
         rend.bytes[2] = CH_CARET;
         rend.bytes[3] = CH_QMARK;
         rend.count    = 3'd4;
      end else if (cfg.show_ctrl && ch >= CH_META) begin
         rend.bytes[0] = CH_UPPERM;
         rend.bytes[1] = CH_DASH;
         rend.bytes[2] = {1'b0, ch[6:0]};
         rend.count    = 3'd3;
      end else if (cfg.show_ctrl && ch >= CH_HIGH) begin
         rend.bytes[0] = CH_UPPERM;
         rend.bytes[1] = CH_DASH;
         rend.bytes[2] = CH_CARET;
         rend.bytes[3] = {2'b01, ch[5:0]};
         rend.count    = 3'd4;
      end else begin
         rend.bytes[0] = ch;
      end
   end

   // A squeezed newline leaves without touching the output stage
   assign a_move      = a_valid_ff && (drop || item_ready);
   assign in_ready    = !a_valid_ff || a_move;
   assign item_valid  = a_valid_ff && !drop;
   assign item_num_en = num_en;
   assign item_digits = count_ff;
   assign item_sig    = sig;
   assign item_rend   = rend;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_byte_in  = a_byte_ff;
      a_fs_in    = a_fs_ff;
      prev_nl_in = prev_nl_ff;
      blank_in   = blank_ff;
      count_in   = count_ff;
      if (a_move && !drop) begin
         prev_nl_in = is_nl;
         blank_in   = cfg.squeeze_blank && prev_eff && is_nl;
         if (num_en) count_in = count_inc;
      end
      if (in_ready) begin
         a_valid_in = in_valid;
         a_byte_in  = in_byte;
         a_fs_in    = in_file_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         prev_nl_ff <= 1'b1;
         blank_ff   <= 1'b0;
         count_ff   <= CW'(1);
      end else begin
         a_valid_ff <= a_valid_in;
         prev_nl_ff <= prev_nl_in;
         blank_ff   <= blank_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_byte_ff <= a_byte_in;
      a_fs_ff   <= a_fs_in;
   end

endmodule

`default_nettype wire

// File: design/tslne_out.sv
// tslne_out: result register that plays out the line number field and the
// rendered character one word at a time. Depends on tslne_pkg.
`default_nettype none

module tslne_out #(
   parameter int COUNT_DIGITS = tslne_pkg::COUNT_DIGITS_DEF,
   parameter int PAD_WIDTH    = tslne_pkg::PAD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   output logic                               item_ready,
   input  logic                               item_num_en,
   input  logic [COUNT_DIGITS*4-1:0]          item_digits,
   input  logic [$clog2(COUNT_DIGITS+1)-1:0]  item_sig,
   input  tslne_pkg::rend_type                item_rend,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [7:0]                         out_byte,
   output logic                               out_last
);
   import tslne_pkg::*;

   localparam int CW      = COUNT_DIGITS * 4;
   localparam int SIG_W   = $clog2(COUNT_DIGITS + 1);
   localparam int NUM_MAX = ((COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH) + 1;
   localparam int CNT_W   = $clog2(NUM_MAX + 1);

   logic             b_valid_ff, b_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIG_W-1:0] sig_ff, sig_in;
   logic [CW-1:0]    dig_ff, dig_in;
   logic [3:0][7:0]  rbytes_ff, rbytes_in;
   logic [2:0]       rcnt_ff, rcnt_in;

   logic             hs, load;
   logic [CNT_W-1:0] sig_ext, pad, num_len, pos;
   logic [3:0]       dsel;

   assign out_valid  = b_valid_ff;
   assign out_last   = (cnt_ff == '0) && (rcnt_ff == 3'd1);
   assign hs         = b_valid_ff && out_ready;
   assign item_ready = !b_valid_ff || (hs && out_last);
   assign load       = item_valid && item_ready;

   assign sig_ext = CNT_W'(item_sig);
   assign pad     = CNT_W'(PAD_WIDTH);
   assign num_len = ((sig_ext > pad) ? sig_ext : pad) + CNT_W'(1);

   // Field position counted from the least significant digit
   assign pos = cnt_ff - CNT_W'(2);

   always_comb begin
      dsel = 4'd0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (pos == CNT_W'(i)) dsel = dig_ff[4*i +: 4];
      end
   end

   always_comb begin
      if (cnt_ff == CNT_W'(1)) begin
         out_byte = CH_TAB;
      end else if (cnt_ff != '0) begin
         out_byte = (pos < CNT_W'(sig_ff)) ? (CH_ZERO | {4'd0, dsel}) : CH_SPACE;
      end else begin
         out_byte = rbytes_ff[0];
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      cnt_in     = cnt_ff;
      sig_in     = sig_ff;
      dig_in     = dig_ff;
      rbytes_in  = rbytes_ff;
      rcnt_in    = rcnt_ff;
      if (load) begin
         b_valid_in = 1'b1;
         cnt_in     = item_num_en ? num_len : '0;
         sig_in     = item_sig;
         dig_in     = item_digits;
         rbytes_in  = item_rend.bytes;
         rcnt_in    = item_rend.count;
      end else if (hs) begin
         if (out_last) begin
            b_valid_in = 1'b0;
         end else if (cnt_ff != '0) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            rbytes_in = {8'h00, rbytes_ff[3:1]};
            rcnt_in   = rcnt_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         rcnt_ff    <= 3'd1;
      end else begin
         b_valid_ff <= b_valid_in;
         cnt_ff     <= cnt_in;
         rcnt_ff    <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff    <= sig_in;
      dig_ff    <= dig_in;
      rbytes_ff <= rbytes_in;
   end

endmodule

`default_nettype wire

// File: design/text_stream_line_number_escape_unit.sv
// text_stream_line_number_escape_unit: top level of the cat-style text
// renderer. Depends on tslne_pkg, tslne_csr, tslne_core and tslne_out.
//
//   channel | direction | tdata / data         | side band
//   --------+-----------+----------------------+------------------------
//   req_    | in        | [7:0] in_byte        | tuser: file_start
//   rsp_    | out       | [7:0] out_byte       | tlast: last word of item
//   csr_    | in/out    | 32-bit registers 0-4 | paddr = 4 * index
//
// Flow: one input word per cycle while the result side keeps up; an item
//   that renders as N words holds the result port until its last word is
//   taken (N is 1 to 15: the number field, when printed, plus one to four
//   words of the character itself).
// Path: input register, then result register, before the first result word.
// Stalls: an empty input register takes a word while the result register
//   drains; a squeezed newline leaves it without waiting on the result side.
// Reset: synchronous; state returns at once, no clearing pass.
`default_nettype none

module text_stream_line_number_escape_unit #(
   parameter int COUNT_DIGITS = tslne_pkg::COUNT_DIGITS_DEF,
   parameter int PAD_WIDTH    = tslne_pkg::PAD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // input stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] in_byte
   input  logic                         req_tuser,   // [0] file_start
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tslne_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tslne_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tslne_pkg::CSR_DW-1:0] csr_prdata,
   output logic                         csr_pready
);
   import tslne_pkg::*;

   localparam int SIG_W = $clog2(COUNT_DIGITS + 1);

   cfg_type                   cfg;
   logic                      item_valid, item_ready, item_num_en;
   logic [COUNT_DIGITS*4-1:0] item_digits;
   logic [SIG_W-1:0]          item_sig;
   rend_type                  item_rend;

   // Mode registers
   tslne_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Hold the input word, advance the line state, render the character
   tslne_core #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_byte       (req_tdata),
      .in_file_start (req_tuser),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item_num_en   (item_num_en),
      .item_digits   (item_digits),
      .item_sig      (item_sig),
      .item_rend     (item_rend)
   );

   // Play out the number field, then the rendered bytes
   tslne_out #(
      .COUNT_DIGITS (COUNT_DIGITS),
      .PAD_WIDTH    (PAD_WIDTH)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item_num_en (item_num_en),
      .item_digits (item_digits),
      .item_sig    (item_sig),
      .item_rend   (item_rend),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: design/tslne_chk.sv
// tslne_chk: port-level checks for the text renderer, bound to the top level.
// Depends on tslne_pkg and text_stream_line_number_escape_unit.
`default_nettype none

module tslne_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [7:0]                   rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         csr_psel,
   input logic                         csr_penable,
   input logic                         csr_pwrite,
   input logic [tslne_pkg::CSR_AW-1:0] csr_paddr,
   input logic [tslne_pkg::CSR_DW-1:0] csr_pwdata,
   input logic [tslne_pkg::CSR_DW-1:0] csr_prdata,
   input logic                         csr_pready
);
   import tslne_pkg::*;

   logic wr_mode;
   assign wr_mode = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[CSR_AW-1:2] == REG_NUMBER_MODE);

   // Reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

   // Input only backs up behind a waiting result
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // Numbering mode reads back what was written
   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      wr_mode ##1 (csr_paddr[CSR_AW-1:2] == REG_NUMBER_MODE) |->
         (csr_prdata[1:0] == $past(csr_pwdata[1:0])))
      else $error("numbering mode readback mismatch");

endmodule

bind text_stream_line_number_escape_unit tslne_chk u_chk (.*);

`default_nettype wire

// File: bench/text_stream_line_number_escape_unit_test.sv
// Self-checking bench for the cat-style text renderer: directed rows, then
// random text phases under random stalls. Depends on tslne_pkg and the
// text_stream_line_number_escape_unit top level.
`timescale 1ns / 100ps

module text_stream_line_number_escape_unit_test;
   import tslne_pkg::*;

   localparam int DIGITS      = COUNT_DIGITS_DEF;
   localparam int PAD         = PAD_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400_000;

   // Register index past the end of the map, and the numbering codes that the
   // package leaves unnamed
   localparam logic [2:0] REG_SPARE  = 3'd5;
   localparam logic [1:0] NUM_NONE   = 2'd0;
   localparam logic [1:0] NUM_UNUSED = 2'd3;

   // One row of stimulus: either a register write or an input word. A word
   // row may carry its rendering typed in; otherwise the predictor decides.
   typedef struct packed {
      logic             is_write;
      logic [2:0]       reg_idx;
      logic [31:0]      value;
      logic [7:0]       ch;
      logic             fs;
      logic             given;
      logic [3:0]       text_len;
      logic [11:0][7:0] text;
   } plan_step_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       tail;
   } text_word_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata   = '0;   // [7:0] in_byte
   logic                req_tuser   = 1'b0; // [0] file_start
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [7:0]          rsp_tdata;          // [7:0] out_byte
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   text_stream_line_number_escape_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor: settings as the block holds them, line state, BCD line count
   // ------------------------------------------------------------------------
   logic [1:0]          cfg_number   = NUM_NONE;
   logic                cfg_squeeze  = 1'b0;
   logic                cfg_ends     = 1'b0;
   logic                cfg_tabs     = 1'b0;
   logic                cfg_nonprint = 1'b0;
   logic                after_nl     = 1'b1;  // as if a newline came before
   logic                squeezing    = 1'b0;  // inside a run of blank lines
   logic [4*DIGITS-1:0] line_bcd     = {{(4*DIGITS-1){1'b0}}, 1'b1};

   logic [7:0]     rendered[$];      // words of the item just rendered
   text_word_type  awaited_text[$];  // words still to come, oldest first
   plan_step_type  sent_rows[$];     // words driven but not yet accepted
   plan_step_type  plan[$];
   int             mismatches  = 0;
   int             cycle_count = 0;
   int             rsp_hold    = 0;
   bit             quiet       = 1'b0;  // no idling on either side while set

   function int idle_cycles();
      return quiet ? 0 : $urandom_range(0, 8);
   endfunction

   // Print the line number right-justified with a tab, then advance the count
   // unless every digit is already nine.
   function void number_line();
      int i;
      int top;
      logic full;
      logic carry;
      top = 1;
      full = 1'b1;
      for (i = 0; i < DIGITS; i++) begin
         if (line_bcd[4*i +: 4] != 4'd0) top = i + 1;
         if (line_bcd[4*i +: 4] != 4'd9) full = 1'b0;
      end
      for (i = top; i < PAD; i++) rendered.push_back(CH_SPACE);
      for (i = top - 1; i >= 0; i--) rendered.push_back(CH_ZERO + {4'd0, line_bcd[4*i +: 4]});
      rendered.push_back(CH_TAB);
      carry = !full;
      for (i = 0; i < DIGITS; i++) begin
         if (carry) begin
            if (line_bcd[4*i +: 4] == 4'd9) begin
               line_bcd[4*i +: 4] = 4'd0;
            end else begin
               line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
   endfunction

   // Render one accepted input byte into `rendered` and advance the state.
   function void render_word(input logic [7:0] ch, input logic file_start);
      logic       is_nl;
      logic       first_line;
      logic [7:0] c;
      rendered.delete();
      is_nl = (ch == CH_NL);
      first_line = (line_bcd == 1);
      // a new file forgets the previous character
      if (file_start) begin
         after_nl = 1'b0;
         squeezing = 1'b0;
      end
      // drop a further blank line without touching the state
      if (cfg_squeeze && squeezing && is_nl) return;
      squeezing = cfg_squeeze && after_nl && is_nl;
      if (cfg_number == NUM_ALL && (after_nl || first_line)) begin
         number_line();
      end else if (cfg_number == NUM_TEXT_ONLY && !is_nl && (after_nl || first_line)) begin
         number_line();
      end
      if (cfg_ends && is_nl) rendered.push_back(CH_DOLLAR);
      if (cfg_tabs && ch == CH_TAB) begin
         rendered.push_back(CH_CARET);
         rendered.push_back(CH_UPPERI);
      end else begin
         c = ch;
         if (cfg_nonprint) begin
            if (ch < CH_SPACE && !is_nl && ch != CH_TAB) begin
               rendered.push_back(CH_CARET);
               c = ch + 8'd64;
            end else if (ch == CH_DEL) begin
               rendered.push_back(CH_CARET);
               c = CH_QMARK;
            end else if (ch >= CH_HIGH) begin
               rendered.push_back(CH_UPPERM);
               rendered.push_back(CH_DASH);
               if (ch == CH_MAX) begin
                  // top byte shows as M-^? rather than a stray printable
                  rendered.push_back(CH_CARET);
                  c = CH_QMARK;
               end else if (ch >= CH_META) begin
                  c = ch - 8'd128;
               end else begin
                  rendered.push_back(CH_CARET);
                  c = ch - 8'd64;
               end
            end
         end
         rendered.push_back(c);
      end
      after_nl = is_nl;
   endfunction

   // ------------------------------------------------------------------------
   // Directed table builders
   // ------------------------------------------------------------------------
   function void plan_word(input logic [7:0] ch, input logic fs, input bit given,
                           input string text);
      plan_step_type s;
      int i;
      s = '0;
      s.ch = ch;
      s.fs = fs;
      s.given = given;
      s.text_len = 4'(text.len());
      for (i = 0; i < text.len(); i++) s.text[i] = text[i];
      plan.push_back(s);
   endfunction

   function void plan_write(input logic [2:0] idx, input logic [31:0] value);
      plan_step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.reg_idx = idx;
      s.value = value;
      plan.push_back(s);
   endfunction

   // ------------------------------------------------------------------------
   // Result side: predict on every accepted input word, check every accepted
   // result word, and stall the result port at random.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      plan_step_type row;
      text_word_type w;
      int k;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            row = '0;
            if (sent_rows.size() != 0) row = sent_rows.pop_front();
            render_word(req_tdata, req_tuser);
            // typed-in rows replace the predictor's words, state still advances
            if (row.given) begin
               for (k = 0; k < row.text_len; k++) begin
                  w.ch = row.text[k];
                  w.tail = (k == row.text_len - 1);
                  awaited_text.push_back(w);
               end
            end else begin
               for (k = 0; k < rendered.size(); k++) begin
                  w.ch = rendered[k];
                  w.tail = (k == rendered.size() - 1);
                  awaited_text.push_back(w);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_text.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %02h last %0b", rsp_tdata, rsp_tlast);
            end else begin
               w = awaited_text.pop_front();
               if (rsp_tdata !== w.ch || rsp_tlast !== w.tail) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %02h last %0b, got %02h last %0b",
                              w.ch, w.tail, rsp_tdata, rsp_tlast);
               end
            end
            rsp_hold = idle_cycles();
            rsp_tready <= (rsp_hold == 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= (rsp_hold == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hard stop if the stream stalls for good
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("text_stream_line_number_escape_unit_test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------

   // Drive one input word after a random gap; return at its acceptance edge.
   task send_step(input plan_step_type s);
      int gap;
      sent_rows.push_back(s);
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s.ch;
      req_tuser  <= s.fs;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, wait for every awaited word, then cover the pipeline latency
   // so a squeezed newline still in flight has cleared.
   task settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_text.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup phase, access phase, then the select drops so back-to-back writes
   // never assign the select twice in one step.
   task write_reg(input logic [2:0] idx, input logic [31:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_NUMBER_MODE:   cfg_number   = value[1:0];
         REG_SQUEEZE_BLANK: cfg_squeeze  = value[0];
         REG_SHOW_ENDS:     cfg_ends     = value[0];
         REG_SHOW_TABS:     cfg_tabs     = value[0];
         REG_SHOW_CTRL:     cfg_nonprint = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      plan_step_type s;
      int p;
      int r;
      int n;
      int roll;
      logic [31:0] v;

      // Defaults after reset: plain pass-through
      plan_word("A", 1'b0, 1'b1, "A");
      plan_word(CH_MAX, 1'b0, 1'b0, "");
      // Everything on; the count still reads one, so the first line gets its
      // number even with the file-start flag clearing the newline state
      plan_write(REG_NUMBER_MODE, 32'(NUM_ALL));
      plan_write(REG_SQUEEZE_BLANK, 1);
      plan_write(REG_SHOW_ENDS, 1);
      plan_write(REG_SHOW_TABS, 1);
      plan_write(REG_SHOW_CTRL, 1);
      plan_word("x", 1'b1, 1'b1, "     1\tx");
      plan_word(CH_TAB, 1'b0, 1'b1, "^I");
      plan_word(CH_NL, 1'b0, 1'b1, "$\n");
      plan_word(CH_NL, 1'b0, 1'b1, "     2\t$\n");
      plan_word(CH_NL, 1'b0, 1'b1, "");           // squeezed away
      plan_word(CH_DEL, 1'b0, 1'b1, "     3\t^?");
      plan_word(8'h00, 1'b0, 1'b1, "^@");
      plan_word(CH_HIGH, 1'b0, 1'b1, "M-^@");
      plan_word(8'h9F, 1'b0, 1'b1, "M-^_");
      plan_word(CH_META, 1'b0, 1'b1, "M- ");
      plan_word(8'hFE, 1'b0, 1'b1, "M-~");
      plan_word(CH_MAX, 1'b0, 1'b1, "M-^?");
      plan_word(8'h1F, 1'b0, 1'b1, "^_");
      plan_word(CH_NL, 1'b0, 1'b1, "$\n");
      plan_word("a", 1'b1, 1'b1, "a");           // new file: no number
      // Non-blank numbering, all display options off
      plan_write(REG_NUMBER_MODE, 32'(NUM_TEXT_ONLY));
      plan_write(REG_SQUEEZE_BLANK, 0);
      plan_write(REG_SHOW_ENDS, 0);
      plan_write(REG_SHOW_TABS, 0);
      plan_write(REG_SHOW_CTRL, 0);
      plan_word(CH_NL, 1'b0, 1'b1, "\n");
      plan_word(CH_NL, 1'b0, 1'b1, "\n");
      plan_word("b", 1'b0, 1'b1, "     4\tb");
      plan_word(CH_TAB, 1'b0, 1'b1, "\t");
      plan_word(CH_HIGH, 1'b0, 1'b0, "");
      // Unused numbering code, a write past the map, junk above a flag bit
      plan_write(REG_NUMBER_MODE, 32'(NUM_UNUSED));
      plan_write(REG_SPARE, 32'hFFFF_FFFF);
      plan_write(REG_SHOW_ENDS, 32'hFFFF_FFFE);
      plan_word(CH_NL, 1'b1, 1'b1, "\n");
      plan_word("c", 1'b0, 1'b1, "c");

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            write_reg(plan[i].reg_idx, plan[i].value);
         end else begin
            send_step(plan[i]);
         end
      end

      // Random text in phases, each under its own settings; two phases run
      // with no idling at all
      for (p = 0; p < 6; p++) begin
         quiet = 1'b0;
         for (r = REG_NUMBER_MODE; r <= REG_SHOW_CTRL; r++) begin
            case (p)
               0:       v = (r == REG_NUMBER_MODE) ? 32'(NUM_ALL) : 32'd1;
               1:       v = 32'd0;
               2:       v = 32'hFFFF_FFFF;
               3:       v = (r == REG_NUMBER_MODE) ? 32'(NUM_TEXT_ONLY) : 32'd1;
               default: v = $urandom;
            endcase
            write_reg(3'(r), v);
         end
         quiet = (p % 3 == 2);
         for (n = 0; n < 50; n++) begin
            s = '0;
            // mostly printable text with frequent line breaks and blank runs
            roll = $urandom_range(0, 99);
            if (roll < 22)      s.ch = CH_NL;
            else if (roll < 27) s.ch = CH_TAB;
            else if (roll < 37) s.ch = 8'($urandom_range(0, 31));
            else if (roll < 40) s.ch = CH_DEL;
            else if (roll < 52) s.ch = 8'($urandom_range(128, 255));
            else                s.ch = 8'($urandom_range(32, 126));
            s.fs = ($urandom_range(0, 19) == 0);
            send_step(s);
         end
      end

      settle();
      if (mismatches == 0 && awaited_text.size() == 0) begin
         $display("text_stream_line_number_escape_unit_test passed");
      end else begin
         $display("text_stream_line_number_escape_unit_test failed");
      end
      $finish;
   end

endmodule
